/* design/pgfb_pkg.sv */
// Shared types and codes of the packed gray framebuffer drawing engine.
`default_nettype none
package pgfb_pkg;

  // Item kinds.
  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_RECT   = 3'd1;
  localparam logic [2:0] KIND_BSTART = 3'd2;
  localparam logic [2:0] KIND_BBYTE  = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // Row coordinates reach past the panel while a bitmap is scanned.
  localparam int ROW_W = 10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic dispatch;
    logic sweep;
    logic walk_rd;
    logic walk_wr;
    logic read_rd;
    logic result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic go_walk;
    logic go_read;
    logic sweep_last;
    logic walk_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* design/pgfb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pgfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/pgfb_ctrl.sv */
// Controller state machine of the drawing engine.
`default_nettype none
module pgfb_ctrl
  import pgfb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_SWEEP,
    S_WALK_RD,
    S_WALK_WR,
    S_READ,
    S_RESULT
  } state_t;

  state_t state;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      unique case (state)
        S_INIT: if (stat.sweep_last) state <= S_IDLE;
        S_IDLE: if (in_valid) state <= S_DISPATCH;
        S_DISPATCH: begin
          if (stat.is_clear) state <= S_SWEEP;
          else if (stat.go_walk) state <= S_WALK_RD;
          else if (stat.go_read) state <= S_READ;
          else state <= S_RESULT;
        end
        S_SWEEP: if (stat.sweep_last) state <= S_RESULT;
        S_WALK_RD: state <= S_WALK_WR;
        S_WALK_WR: if (stat.walk_last) state <= S_RESULT;
                   else state <= S_WALK_RD;
        S_READ: state <= S_RESULT;
        S_RESULT: if (stat.out_free) state <= S_IDLE;
        default: state <= S_INIT;
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.dispatch = (state == S_DISPATCH);
    cmd.sweep    = (state == S_INIT) || (state == S_SWEEP);
    cmd.walk_rd  = (state == S_WALK_RD);
    cmd.walk_wr  = (state == S_WALK_WR);
    cmd.read_rd  = (state == S_READ);
    cmd.result   = (state == S_RESULT) && stat.out_free;
  end

  assign in_stall = (state != S_IDLE);

endmodule
`default_nettype wire

/* design/pgfb_dpath.sv */
// Datapath: item decode, bitmap state, byte walker, store and result register.
`default_nettype none
module pgfb_dpath
  import pgfb_pkg::*;
#(
  parameter int PANEL_WIDTH  = 212,
  parameter int PANEL_HEIGHT = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  output stat_t           stat,
  input  wire logic [2:0] kind,
  input  wire logic [7:0] x_pos,
  input  wire logic [7:0] y_pos,
  input  wire logic [7:0] span_w,
  input  wire logic [7:0] span_h,
  input  wire logic       erase,
  input  wire logic [7:0] pattern,
  input  wire logic [12:0] address,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            status,
  output logic [7:0]      read_data
);

  localparam int DEPTH = PANEL_WIDTH * ((PANEL_HEIGHT + 1) / 2);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [7:0]       W8    = 8'(PANEL_WIDTH);
  localparam logic [7:0]       H8    = 8'(PANEL_HEIGHT);
  localparam logic [ROW_W-1:0] HLAST = ROW_W'(PANEL_HEIGHT - 1);

  // Bitmap state.
  logic [7:0] blit_origin_x, blit_origin_y, blit_width, blit_column;
  logic [5:0] blit_bands, blit_band;
  logic       blit_invert, blit_active;

  // Latched item and walk parameters.
  logic [2:0]       kind_q;
  logic [12:0]      address_q;
  logic             rej_q, go_walk_q, go_read_q;
  logic [7:0]       col_lo, col_hi, col;
  logic [ROW_W-1:0] ylo, yhi;
  logic [ROW_W-2:0] rp, rp_end;
  logic [7:0]       pat_q;
  logic [AW-1:0]    base;
  logic [AW-1:0]    sweep_addr;

  // Rectangle decode with clipping.
  logic       rect_rej;
  logic [7:0] x_room, y_room, wc, hc;
  always_comb begin
    rect_rej = (x_pos >= W8) || (y_pos >= H8);
    x_room   = W8 - x_pos;
    y_room   = H8 - y_pos;
    wc       = (span_w > x_room) ? x_room : span_w;
    hc       = (span_h > y_room) ? y_room : span_h;
  end

  // Bitmap byte decode: mirrored column and band rows.
  logic [8:0]       b_sum;
  logic             b_col_ok, b_row_ok;
  logic [ROW_W-1:0] b_top, b_bot;
  always_comb begin
    b_sum    = 9'(blit_origin_x) + 9'(blit_column);
    b_col_ok = b_sum <= 9'(PANEL_WIDTH - 1);
    b_top    = ROW_W'(blit_origin_y) + ROW_W'({blit_band, 3'b000});
    b_row_ok = b_top <= HLAST;
    b_bot    = b_top + ROW_W'(7);
  end

  // Walk parameters chosen by kind.
  logic             a_rej, a_walk, a_read;
  logic [7:0]       a_col_lo, a_col_hi, a_pat;
  logic [ROW_W-1:0] a_ylo, a_yhi;
  always_comb begin
    a_rej    = 1'b0;
    a_walk   = 1'b0;
    a_read   = 1'b0;
    a_col_lo = W8 - x_pos - wc;
    a_col_hi = W8 - 8'd1 - x_pos;
    a_ylo    = ROW_W'(y_pos);
    a_yhi    = ROW_W'(y_pos) + ROW_W'(hc) - ROW_W'(1);
    a_pat    = {8{~erase}};
    case (kind)
      KIND_RECT: begin
        a_rej  = rect_rej;
        a_walk = !rect_rej && (wc != 8'd0) && (hc != 8'd0);
      end
      KIND_BBYTE: begin
        a_rej    = !blit_active;
        a_walk   = blit_active && b_col_ok && b_row_ok;
        a_col_lo = 8'(9'(PANEL_WIDTH - 1) - b_sum);
        a_col_hi = 8'(9'(PANEL_WIDTH - 1) - b_sum);
        a_ylo    = b_top;
        a_yhi    = (b_bot > HLAST) ? HLAST : b_bot;
        a_pat    = blit_invert ? ~pattern : pattern;
      end
      KIND_READ: begin
        a_rej  = 32'(address) >= DEPTH;
        a_read = !a_rej;
      end
      default: ;
    endcase
  end

  // Control registers: bitmap state, sweep counter, result valid.
  logic [8:0] col_inc;
  logic [6:0] band_inc;
  assign col_inc  = 9'(blit_column) + 9'd1;
  assign band_inc = 7'(blit_band) + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blit_origin_x <= '0;
      blit_origin_y <= '0;
      blit_width    <= '0;
      blit_bands    <= '0;
      blit_column   <= '0;
      blit_band     <= '0;
      blit_invert   <= 1'b0;
      blit_active   <= 1'b0;
      sweep_addr    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.accept && kind == KIND_BSTART) begin
        blit_origin_x <= x_pos;
        blit_origin_y <= y_pos;
        blit_width    <= span_w;
        blit_bands    <= 6'((9'(span_h) + 9'd7) >> 3);
        blit_column   <= '0;
        blit_band     <= '0;
        blit_invert   <= erase;
        blit_active   <= (span_w != 8'd0) && (span_h != 8'd0);
      end else if (cmd.accept && kind == KIND_BBYTE && blit_active) begin
        if (col_inc >= 9'(blit_width)) begin
          blit_column <= '0;
          if (band_inc >= 7'(blit_bands)) begin
            blit_band   <= '0;
            blit_active <= 1'b0;
          end else begin
            blit_band <= 6'(band_inc);
          end
        end else begin
          blit_column <= 8'(col_inc);
        end
      end
      if (cmd.accept) begin
        sweep_addr <= '0;
      end else if (cmd.sweep) begin
        sweep_addr <= sweep_addr + AW'(1);
      end
      if (cmd.result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Store.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr, walk_addr;
  logic [7:0]    ram_wdata, ram_q;

  pgfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Merge the two rows of the current row pair into the old byte.
  logic [ROW_W-1:0] r_even, r_odd, d_even, d_odd;
  logic             in_even, in_odd, bit_even, bit_odd;
  logic [7:0]       new_byte;
  always_comb begin
    walk_addr = base + AW'(col);
    r_even    = {rp, 1'b0};
    r_odd     = {rp, 1'b1};
    d_even    = r_even - ylo;
    d_odd     = r_odd - ylo;
    in_even   = (r_even >= ylo) && (r_even <= yhi);
    in_odd    = (r_odd >= ylo) && (r_odd <= yhi);
    bit_even  = pat_q[~d_even[2:0]];
    bit_odd   = pat_q[~d_odd[2:0]];
    new_byte[7:4] = in_even ? {4{bit_even}} : ram_q[7:4];
    new_byte[3:0] = in_odd ? {4{bit_odd}} : ram_q[3:0];
  end

  always_comb begin
    ram_we    = cmd.sweep || cmd.walk_wr;
    ram_waddr = cmd.sweep ? sweep_addr : walk_addr;
    ram_wdata = cmd.sweep ? 8'h00 : new_byte;
    ram_re    = cmd.walk_rd || cmd.read_rd;
    ram_raddr = cmd.read_rd ? AW'(address_q) : walk_addr;
  end

  // Item latch, walk counters and result payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q    <= kind;
      address_q <= address;
      rej_q     <= a_rej;
      go_walk_q <= a_walk;
      go_read_q <= a_read;
      col_lo    <= a_col_lo;
      col_hi    <= a_col_hi;
      col       <= a_col_lo;
      ylo       <= a_ylo;
      yhi       <= a_yhi;
      rp        <= a_ylo[ROW_W-1:1];
      rp_end    <= a_yhi[ROW_W-1:1];
      pat_q     <= a_pat;
    end
    if (cmd.dispatch) begin
      base <= AW'(32'(rp) * PANEL_WIDTH);
    end
    if (cmd.walk_wr) begin
      if (col == col_hi) begin
        col  <= col_lo;
        rp   <= rp + (ROW_W-1)'(1);
        base <= base + AW'(PANEL_WIDTH);
      end else begin
        col <= col + 8'd1;
      end
    end
    if (cmd.result) begin
      status    <= rej_q;
      read_data <= go_read_q ? ram_q : 8'h00;
    end
  end

  // Status to the controller.
  always_comb begin
    stat            = '0;
    stat.is_clear   = (kind_q == KIND_CLEAR);
    stat.go_walk    = go_walk_q;
    stat.go_read    = go_read_q;
    stat.sweep_last = (sweep_addr == AW'(DEPTH - 1));
    stat.walk_last  = (col == col_hi) && (rp == rp_end);
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

/* design/packed_gray_framebuffer_draw.sv */
// Top level of the packed 4-bit gray framebuffer drawing engine.
// A read item reads one store byte; a bitmap start, a rejected or an ignored item
// touches no store byte; a bitmap byte walks its touched row pairs (at most 5), a
// rectangle its touched bytes, and a clear all sweeps every store byte. One item at a time:
// the next transfer in is taken once the result is loaded into its output register, and
// each touched byte is read and then written back, in states WALK_RD and WALK_WR.
// Reset: a clearing pass zeros all PANEL_WIDTH*ceil(PANEL_HEIGHT/2) store bytes.
`default_nettype none
module packed_gray_framebuffer_draw
  import pgfb_pkg::*;
#(
  parameter int PANEL_WIDTH  = 212,
  parameter int PANEL_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [7:0]  x_pos,
  input  wire logic [7:0]  y_pos,
  input  wire logic [7:0]  span_w,
  input  wire logic [7:0]  span_h,
  input  wire logic        erase,
  input  wire logic [7:0]  pattern,
  input  wire logic [12:0] address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             status,
  output logic [7:0]       read_data
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  pgfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath and store.
  pgfb_dpath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .kind      (kind),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .span_w    (span_w),
    .span_h    (span_h),
    .erase     (erase),
    .pattern   (pattern),
    .address   (address),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .read_data (read_data)
  );

endmodule
`default_nettype wire

/* tb/sv/packed_gray_framebuffer_draw_tb.sv */
// Self-checking testbench of the packed gray framebuffer drawing engine.
`default_nettype none
module packed_gray_framebuffer_draw_tb;
  import pgfb_pkg::*;

  localparam int PANEL_WIDTH  = 212;
  localparam int PANEL_HEIGHT = 64;
  localparam int STORE_DEPTH  = PANEL_WIDTH * ((PANEL_HEIGHT + 1) / 2);
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = STORE_DEPTH + 50;

  // Codes of the kind field that the engine ignores.
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic       status;
    logic [7:0] read_data;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = KIND_CLEAR;
  logic [7:0]  x_pos = '0;
  logic [7:0]  y_pos = '0;
  logic [7:0]  span_w = '0;
  logic [7:0]  span_h = '0;
  logic        erase = 1'b0;
  logic [7:0]  pattern = '0;
  logic [12:0] address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [7:0]  read_data;

  packed_gray_framebuffer_draw #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .x_pos    (x_pos),
    .y_pos    (y_pos),
    .span_w   (span_w),
    .span_h   (span_h),
    .erase    (erase),
    .pattern  (pattern),
    .address  (address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .read_data(read_data)
  );

  // Shadow copy of the engine's state.
  logic [7:0] shadow_store [STORE_DEPTH];
  logic [7:0] open_x, open_y, open_w, open_bands, open_col, open_band;
  logic       open_invert, open_live;

  reply_t     replies_due [$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         items_sent = 0;
  int         replies_seen = 0;
  bit         send_idles = 1'b1;
  bit         recv_idles = 1'b1;
  int         hold_off = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("Mismatch on %s at cycle %0d: got %0d, expected %0d",
             what, cycle_count, got, want);
    error_count++;
  endtask

  // Set or clear one pixel at a physical column and row, dropping it if outside.
  function automatic void shade_pixel(input int col, input int row, input bit on);
    int idx;
    if (col < 0 || col >= PANEL_WIDTH || row < 0 || row >= PANEL_HEIGHT) return;
    idx = (row / 2) * PANEL_WIDTH + col;
    if (row % 2 == 1)
      shadow_store[idx] = on ? (shadow_store[idx] | 8'h0F) : (shadow_store[idx] & 8'hF0);
    else
      shadow_store[idx] = on ? (shadow_store[idx] | 8'hF0) : (shadow_store[idx] & 8'h0F);
  endfunction

  function automatic void wipe_shadow();
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
  endfunction

  // Work out the reply of one item and advance the shadow state.
  function automatic reply_t draw_reply(input logic [2:0] k, input logic [7:0] xp,
                                        input logic [7:0] yp, input logic [7:0] w8,
                                        input logic [7:0] h8, input logic er,
                                        input logic [7:0] pat, input logic [12:0] addr);
    reply_t r;
    int w, h, col, top;
    logic [7:0] p;
    r = '0;
    w = w8;
    h = h8;
    case (k)
      KIND_CLEAR: wipe_shadow();
      KIND_RECT: begin
        if (xp >= PANEL_WIDTH || yp >= PANEL_HEIGHT) begin
          r.status = 1'b1;
        end else begin
          if (xp + w > PANEL_WIDTH) w = PANEL_WIDTH - xp;
          if (yp + h > PANEL_HEIGHT) h = PANEL_HEIGHT - yp;
          for (int i = 0; i < w; i++)
            for (int j = 0; j < h; j++)
              shade_pixel(PANEL_WIDTH - 1 - (xp + i), yp + j, !er);
        end
      end
      KIND_BSTART: begin
        open_x = xp;
        open_y = yp;
        open_w = w8;
        open_bands = 8'((h + 7) / 8);
        open_col = '0;
        open_band = '0;
        open_invert = er;
        open_live = (w != 0 && h != 0);
      end
      KIND_BBYTE: begin
        if (!open_live) begin
          r.status = 1'b1;
        end else begin
          col = PANEL_WIDTH - 1 - int'(open_x) - int'(open_col);
          top = int'(open_y) + 8 * int'(open_band);
          p = open_invert ? ~pat : pat;
          for (int j = 0; j < 8; j++) shade_pixel(col, top + j, p[7 - j]);
          open_col++;
          if (open_col >= open_w) begin
            open_col = '0;
            open_band++;
            if (open_band >= open_bands) begin
              open_band = '0;
              open_live = 1'b0;
            end
          end
        end
      end
      KIND_READ: begin
        if (addr < STORE_DEPTH) r.read_data = shadow_store[addr];
        else r.status = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one item, idle at random beforehand, and hold it until the transfer.
  // Valid stays high after the transfer; the next idle or pause drops it.
  task automatic send_item(input logic [2:0] k, input logic [7:0] xp = 0,
                           input logic [7:0] yp = 0, input logic [7:0] w = 0,
                           input logic [7:0] h = 0, input logic er = 0,
                           input logic [7:0] pat = 0, input logic [12:0] addr = 0);
    while (send_idles && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    x_pos <= xp;
    y_pos <= yp;
    span_w <= w;
    span_h <= h;
    erase <= er;
    pattern <= pat;
    address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    replies_due.push_back(draw_reply(k, xp, yp, w, h, er, pat, addr));
    items_sent++;
  endtask

  // Receiver stall: random, or held for a counted stretch.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else out_stall <= recv_idles && ($urandom_range(99) < 35);
  end

  // Compare each transfer out with the oldest expected reply.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        $display("Unexpected reply at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (read_data !== want.read_data)
          report_mismatch("read_data", read_data, want.read_data);
      end
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic read_back(input int first, input int count);
    for (int a = first; a < first + count && a < STORE_DEPTH; a++)
      send_item(KIND_READ, .addr(13'(a)));
  endtask

  // Corners, clipping, odd rows, empty and rejected rectangles, out-of-range reads and ignored kinds.
  task automatic test_rectangles();
    send_item(KIND_RECT, 0, 0, 8'd3, 8'd3);
    send_item(KIND_RECT, 8'd5, 8'd1, 8'd4, 8'd3);
    send_item(KIND_RECT, 8'd6, 8'd2, 8'd1, 8'd1, 1'b1);
    send_item(KIND_RECT, 8'd211, 8'd63, 8'd255, 8'd255);
    send_item(KIND_RECT, 8'd212, 8'd0, 8'd1, 8'd1);
    send_item(KIND_RECT, 8'd0, 8'd64, 8'd1, 8'd1);
    send_item(KIND_RECT, 8'd255, 8'd255, 8'd1, 8'd1);
    send_item(KIND_RECT, 8'd10, 8'd10, 8'd0, 8'd5);
    send_item(KIND_RECT, 8'd10, 8'd10, 8'd5, 8'd0);
    read_back(0, 3);
    read_back(PANEL_WIDTH - 10, 10);
    read_back(STORE_DEPTH - 2, 2);
    send_item(KIND_READ, .addr(13'd6784));
    send_item(KIND_READ, .addr(13'h1FFF));
    send_item(KIND_SPARE_LO);
    send_item(KIND_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 13'h1FFF);
  endtask

  // Bitmaps: closed, empty, inverted, off the panel, replaced while open.
  task automatic test_bitmaps();
    send_item(KIND_BBYTE, .pat(8'hA5));
    send_item(KIND_BSTART, 8'd0, 8'd0, 8'd0, 8'd8);
    send_item(KIND_BBYTE, .pat(8'hFF));
    send_item(KIND_BSTART, 8'd2, 8'd3, 8'd2, 8'd9, 1'b1);
    for (int i = 0; i < 4; i++) send_item(KIND_BBYTE, .pat(8'h81 << i));
    send_item(KIND_BBYTE, .pat(8'h0F));
    send_item(KIND_BSTART, 8'd210, 8'd60, 8'd4, 8'd8);
    send_item(KIND_BBYTE, .pat(8'hFF));
    send_item(KIND_BSTART, 8'd255, 8'd255, 8'd255, 8'd255);
    send_item(KIND_BBYTE, .pat(8'hFF));
    read_back(0, 8);
    read_back(PANEL_WIDTH * 30, 4);
    send_item(KIND_CLEAR);
    read_back(PANEL_WIDTH - 8, 8);
  endtask

  // Random item with mostly well-formed bitmaps and small rectangles.
  task automatic random_item();
    int pick;
    int w, h, n;
    pick = $urandom_range(99);
    if (pick < 1) send_item(KIND_CLEAR);
    else if (pick < 25) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
      h = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
      send_item(KIND_RECT, ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(211)),
                ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(63)),
                8'(w), 8'(h), 1'($urandom));
    end else if (pick < 55) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 20);
      send_item(KIND_BSTART, ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(211)),
                ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(63)),
                8'(w), 8'(h), 1'($urandom));
      n = w * ((h + 7) / 8) + $urandom_range(0, 1) - $urandom_range(0, 1);
      for (int i = 0; i < n; i++) send_item(KIND_BBYTE, .pat(8'($urandom)));
    end else if (pick < 58) send_item(KIND_BBYTE, .pat(8'($urandom)));
    else if (pick < 60) send_item(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                                   13'($urandom));
    else send_item(KIND_READ, .addr(($urandom_range(19) == 0) ? 13'($urandom)
                                                              : 13'($urandom_range(6783))));
  endtask

  task automatic test_random(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) random_item();
  endtask

  // Long receiver hold-off while items keep coming, then a sender pause and random items with no idles.
  task automatic test_backpressure();
    hold_off <= 400;
    for (int i = 0; i < 20; i++) send_item(KIND_READ, .addr(13'($urandom_range(6783))));
    wait_drained();
    send_idles = 1'b0;
    recv_idles = 1'b0;
    test_random(150);
    send_idles = 1'b1;
    recv_idles = 1'b1;
  endtask

  initial begin
    wipe_shadow();
    open_x = '0; open_y = '0; open_w = '0; open_bands = '0;
    open_col = '0; open_band = '0; open_invert = 1'b0; open_live = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_rectangles();
    test_bitmaps();
    test_backpressure();
    test_random(1300);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items and %0d replies: rectangles, bitmaps, reads, clears,",
             items_sent, replies_seen);
    $display("ignored kinds, rejections and long output back-pressure.");
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
